// ===== design/bccfr_pkg.sv =====
// ----------------------------------------------------------------------------
// bccfr_pkg
// Shared types and constants for the STX/ETX frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package bccfr_pkg;

  localparam int unsigned BUFFER_BYTES_DEF = 1024;
  localparam int unsigned QUEUE_DEPTH_DEF  = 4;

  localparam logic [7:0] STX_BYTE = 8'h02;
  localparam logic [7:0] ETX_BYTE = 8'h03;
  localparam logic [7:0] ACK_BYTE = 8'h06;
  localparam logic [7:0] NAK_BYTE = 8'h15;

  typedef enum logic [2:0] {
    KIND_ACK    = 3'd0,
    KIND_NAK    = 3'd1,
    KIND_STORED = 3'd2,
    KIND_GOOD   = 3'd3,
    KIND_BADSUM = 3'd4,
    KIND_DROP   = 3'd5
  } kind_e;

  typedef enum logic {
    CAUSE_NO_ETX = 1'b0,
    CAUSE_LIMIT  = 1'b1
  } cause_e;

  // Classified byte as passed from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       is_stx;
    logic       is_etx;
    logic       is_ack;
    logic       is_nak;
  } item_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  value;
    logic [9:0]  position;
    logic [10:0] frame_bytes;
    cause_e      drop_cause;
  } result_t;

endpackage

`default_nettype wire

// ===== design/bccfr_front.sv =====
// ----------------------------------------------------------------------------
// bccfr_front
// Input side: takes bytes from the stream and tags the control characters.
// ----------------------------------------------------------------------------
`default_nettype none

module bccfr_front import bccfr_pkg::*; (
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // [7:0] rx_byte
  output logic            push_valid_o,
  input  wire logic       push_ready_i,
  output item_t           push_item_o
);

  assign s_axis_tready_o = push_ready_i;
  assign push_valid_o    = s_axis_tvalid_i;

  always_comb begin
    push_item_o.data   = s_axis_tdata_i;
    push_item_o.is_stx = (s_axis_tdata_i == STX_BYTE);
    push_item_o.is_etx = (s_axis_tdata_i == ETX_BYTE);
    push_item_o.is_ack = (s_axis_tdata_i == ACK_BYTE);
    push_item_o.is_nak = (s_axis_tdata_i == NAK_BYTE);
  end

endmodule

`default_nettype wire

// ===== design/bccfr_fifo.sv =====
// ----------------------------------------------------------------------------
// bccfr_fifo
// Short register queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module bccfr_fifo import bccfr_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_valid_i,
  output logic       push_ready_o,
  input  wire item_t push_item_i,
  output logic       pop_valid_o,
  input  wire logic  pop_ready_i,
  output item_t      pop_item_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  item_t            mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             push, pop;

  assign push_ready_o = (count_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (pop)  rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (push && !pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/bccfr_back.sv =====
// ----------------------------------------------------------------------------
// bccfr_back
// Deframing state machine with a registered result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module bccfr_back import bccfr_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic pop_valid_i,
  output logic      pop_ready_o,
  input  wire item_t pop_item_i,
  output logic      res_valid_o,
  input  wire logic res_ready_i,
  output result_t   res_o
);

  localparam int unsigned CNT_W = $clog2(BUFFER_BYTES);
  localparam int unsigned EXT_W = (CNT_W + 1 > 11) ? CNT_W + 1 : 11;
  localparam logic [CNT_W-1:0] LIMIT = CNT_W'(BUFFER_BYTES - 2);

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_LEN_LO = 3'd1,
    PH_LEN_HI = 3'd2,
    PH_BODY   = 3'd3,
    PH_ETX    = 3'd4,
    PH_CHECK  = 3'd5
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [CNT_W-1:0] stored_q, stored_d;
  logic [15:0]      length_q, length_d;
  logic [15:0]      body_q, body_d;
  logic [7:0]       xor_q, xor_d;
  logic             res_valid_q;
  result_t          res_q, res_d;
  logic             has_res;
  logic             pop;
  logic [EXT_W-1:0] cnt_ext, cnt_inc;
  logic [7:0]       b;
  logic [15:0]      body_inc;

  // Result register frees up when empty or taken this cycle
  assign pop_ready_o = !res_valid_q || res_ready_i;
  assign pop         = pop_valid_i && pop_ready_o;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  assign b        = pop_item_i.data;
  assign cnt_ext  = EXT_W'(stored_q);
  assign cnt_inc  = cnt_ext + EXT_W'(1);
  assign body_inc = body_q + 16'd1;

  always_comb begin
    phase_d  = phase_q;
    stored_d = stored_q;
    length_d = length_q;
    body_d   = body_q;
    xor_d    = xor_q;
    has_res  = 1'b0;
    res_d.kind        = KIND_STORED;
    res_d.value       = b;
    res_d.position    = '0;
    res_d.frame_bytes = '0;
    res_d.drop_cause  = CAUSE_NO_ETX;

    unique case (phase_q)
      PH_LEN_LO: begin
        length_d       = {8'h00, b};
        has_res        = 1'b1;
        res_d.position = cnt_ext[9:0];
        stored_d       = stored_q + CNT_W'(1);
        xor_d          = xor_q ^ b;
        phase_d        = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        length_d       = {b, length_q[7:0]};
        has_res        = 1'b1;
        res_d.position = cnt_ext[9:0];
        stored_d       = stored_q + CNT_W'(1);
        xor_d          = xor_q ^ b;
        phase_d        = PH_BODY;
      end
      PH_BODY: begin
        has_res = 1'b1;
        if (stored_q >= LIMIT) begin
          res_d.kind       = KIND_DROP;
          res_d.drop_cause = CAUSE_LIMIT;
          phase_d  = PH_HUNT;
          stored_d = '0;
          length_d = '0;
          body_d   = '0;
          xor_d    = '0;
        end else begin
          res_d.position = cnt_ext[9:0];
          stored_d       = stored_q + CNT_W'(1);
          xor_d          = xor_q ^ b;
          body_d         = body_inc;
          if (body_inc == length_q) phase_d = PH_ETX;
        end
      end
      PH_ETX: begin
        has_res = 1'b1;
        if (!pop_item_i.is_etx) begin
          res_d.kind = KIND_DROP;
          phase_d  = PH_HUNT;
          stored_d = '0;
          length_d = '0;
          body_d   = '0;
          xor_d    = '0;
        end else begin
          res_d.position = cnt_ext[9:0];
          stored_d       = stored_q + CNT_W'(1);
          xor_d          = xor_q ^ b;
          phase_d        = PH_CHECK;
        end
      end
      PH_CHECK: begin
        has_res           = 1'b1;
        res_d.kind        = (xor_q == b) ? KIND_GOOD : KIND_BADSUM;
        res_d.position    = cnt_ext[9:0];
        res_d.frame_bytes = cnt_inc[10:0];
        phase_d  = PH_HUNT;
        stored_d = '0;
        length_d = '0;
        body_d   = '0;
        xor_d    = '0;
      end
      default: begin
        // hunting; unused codes fall in here as well
        phase_d  = PH_HUNT;
        stored_d = '0;
        length_d = '0;
        body_d   = '0;
        xor_d    = '0;
        if (pop_item_i.is_stx) begin
          phase_d = PH_LEN_LO;
        end else if (pop_item_i.is_ack) begin
          has_res    = 1'b1;
          res_d.kind = KIND_ACK;
        end else if (pop_item_i.is_nak) begin
          has_res    = 1'b1;
          res_d.kind = KIND_NAK;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT;
      stored_q    <= '0;
      length_q    <= '0;
      body_q      <= '0;
      xor_q       <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      if (pop) begin
        phase_q     <= phase_d;
        stored_q    <= stored_d;
        length_q    <= length_d;
        body_q      <= body_d;
        xor_q       <= xor_d;
        res_valid_q <= has_res;
        if (has_res) res_q <= res_d;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/bcc_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// bcc_frame_receiver
// STX / length / body / ETX / XOR check byte deframer for a serial byte link.
// ----------------------------------------------------------------------------
// Slave stream carries one received byte per beat in s_axis_tdata_i[7:0].
// Master stream gives one report per beat: tuser holds the kind (ack, nak,
// stored byte, frame good, checksum error, frame dropped), tdata the byte,
// its position in the stored frame, the frame size and the drop cause.
// Each stored frame byte (length, body, ETX) is reported as it arrives; the
// check byte closes the frame with a good or checksum-error report.
// A report is registered in the result stage after its byte has passed
// through the queue. The block takes one byte per cycle while the master side
// does not stall. A four-entry queue sits between byte intake and the
// deframer, and the report register is refilled in the cycle it is taken.
// When the master side stalls, the queue fills and then tready drops; no
// report is lost. Bytes that produce no report (STX, idle noise) still pass
// through the back end. Reset returns to hunting for STX with an empty queue.
// ----------------------------------------------------------------------------
`default_nettype none

module bcc_frame_receiver import bccfr_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEF,
  parameter int unsigned QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [7:0] value, [17:8] position, [28:18] frame_bytes, [29] drop_cause
  output logic [31:0]      m_axis_tdata_o,
  output logic [2:0]       m_axis_tuser_o    // [2:0] kind
);

  logic    push_valid, push_ready;
  item_t   push_item;
  logic    pop_valid, pop_ready;
  item_t   pop_item;
  result_t res;

  bccfr_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .push_valid_o    (push_valid),
    .push_ready_i    (push_ready),
    .push_item_o     (push_item)
  );

  bccfr_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  bccfr_back #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_item_i  (pop_item),
    .res_valid_o (m_axis_tvalid_o),
    .res_ready_i (m_axis_tready_i),
    .res_o       (res)
  );

  assign m_axis_tuser_o = res.kind;
  assign m_axis_tdata_o = {2'b00, res.drop_cause, res.frame_bytes, res.position, res.value};

endmodule

`default_nettype wire

// ===== tb/tb_bcc_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// tb_bcc_frame_receiver
// Self-checking bench for the STX/ETX frame receiver with XOR check byte.
// A queue of bytes (directed frames first, then random frames and line noise)
// feeds a stream driver; a deframer model predicts each report, and a
// monitor compares every report beat field by field in arrival order.
// Both sides idle at random, the master side holds off once for a long
// stretch, and the sender drains the block now and then before going on.
// ----------------------------------------------------------------------------
module tb_bcc_frame_receiver import bccfr_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_BODY  = BUFFER_BYTES_DEF - 4;
  localparam int unsigned CYCLE_CAP = 1_000_000;

  typedef enum logic [2:0] {
    PH_HUNT, PH_LEN_LO, PH_LEN_HI, PH_BODY, PH_ETX, PH_CHECK
  } rx_phase_e;

  typedef struct {
    logic [7:0] data;
    bit         drain;  // hold this byte back until all reports are in
  } tx_byte_t;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        s_valid = 1'b0;
  logic [7:0]  s_data  = 8'h00;
  logic        s_ready;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [31:0] m_data;
  logic [2:0]  m_user;

  tx_byte_t    byte_q[$];
  result_t     report_q[$];

  int          cycle_cnt  = 0;
  int          beats_in   = 0;
  int          mismatches = 0;
  int          tx_gap     = 0;
  int          rx_stall   = 0;
  int          hold_cnt   = 0;
  bit          hold_done  = 1'b0;

  // deframer model state
  rx_phase_e   ph       = PH_HUNT;
  logic [10:0] st_cnt   = '0;
  logic [15:0] len_f    = '0;
  logic [15:0] body_cnt = '0;
  logic [7:0]  xor_acc  = '0;

  bcc_frame_receiver u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Deframer model
  // --------------------------------------------------------------------------
  function automatic void restart_hunt();
    ph       = PH_HUNT;
    st_cnt   = '0;
    len_f    = '0;
    body_cnt = '0;
    xor_acc  = '0;
  endfunction

  function automatic void store_byte(input logic [7:0] b, inout result_t rep);
    rep.kind     = KIND_STORED;
    rep.position = st_cnt[9:0];
    st_cnt       = st_cnt + 11'd1;
    xor_acc      = xor_acc ^ b;
  endfunction

  function automatic bit deframe_byte(input logic [7:0] b, output result_t rep);
    bit has;
    rep       = '0;
    rep.value = b;
    has       = 1'b1;
    case (ph)
      PH_LEN_LO: begin
        len_f = {8'h00, b};
        store_byte(b, rep);
        ph = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len_f[15:8] = b;
        store_byte(b, rep);
        ph = PH_BODY;
      end
      PH_BODY: begin
        // ETX and check byte must still fit
        if (st_cnt >= 11'(BUFFER_BYTES_DEF - 2)) begin
          rep.kind       = KIND_DROP;
          rep.drop_cause = CAUSE_LIMIT;
          restart_hunt();
        end else begin
          store_byte(b, rep);
          body_cnt = body_cnt + 16'd1;
          if (body_cnt == len_f) ph = PH_ETX;
        end
      end
      PH_ETX: begin
        if (b != ETX_BYTE) begin
          rep.kind       = KIND_DROP;
          rep.drop_cause = CAUSE_NO_ETX;
          restart_hunt();
        end else begin
          store_byte(b, rep);
          ph = PH_CHECK;
        end
      end
      PH_CHECK: begin
        rep.kind        = (xor_acc == b) ? KIND_GOOD : KIND_BADSUM;
        rep.position    = st_cnt[9:0];
        rep.frame_bytes = st_cnt + 11'd1;
        restart_hunt();
      end
      default: begin
        restart_hunt();
        if (b == STX_BYTE) begin
          ph  = PH_LEN_LO;
          has = 1'b0;
        end else if (b == ACK_BYTE) begin
          rep.kind = KIND_ACK;
        end else if (b == NAK_BYTE) begin
          rep.kind = KIND_NAK;
        end else begin
          has = 1'b0;
        end
      end
    endcase
    return has;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // mostly no gap, some short, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_body();
    if ($urandom_range(0, 99) < 12) begin
      case ($urandom_range(0, 3))
        0:       return STX_BYTE;
        1:       return ETX_BYTE;
        2:       return ACK_BYTE;
        default: return NAK_BYTE;
      endcase
    end
    return 8'($urandom);
  endfunction

  task automatic add_byte(input logic [7:0] b, input bit drain = 1'b0);
    tx_byte_t t;
    t.data  = b;
    t.drain = drain;
    byte_q.push_back(t);
  endtask

  // Oversized and zero lengths run into the buffer limit and stop there.
  task automatic add_frame(input int len, input bit etx_ok, input bit sum_ok,
                           input logic [7:0] bad_etx, input bit drain);
    logic [7:0] x;
    logic [7:0] b;
    int         n_body;
    n_body = (len == 0 || len > MAX_BODY) ? MAX_BODY + 1 : len;
    add_byte(STX_BYTE, drain);
    add_byte(len[7:0]);
    add_byte(len[15:8]);
    x = len[7:0] ^ len[15:8];
    for (int i = 0; i < n_body; i++) begin
      b = pick_body();
      add_byte(b);
      x = x ^ b;
    end
    if (n_body > len || len == 0) return;
    if (!etx_ok) begin
      add_byte((bad_etx == ETX_BYTE) ? (bad_etx ^ 8'h01) : bad_etx);
      return;
    end
    add_byte(ETX_BYTE);
    x = x ^ ETX_BYTE;
    add_byte(sum_ok ? x : (x ^ 8'($urandom_range(1, 255))));
  endtask

  // --------------------------------------------------------------------------
  // Driver
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : drv
    result_t rep;
    if (!rst_ni) begin
      s_valid <= 1'b0;
      s_data  <= 8'h00;
      tx_gap  <= 0;
    end else begin
      if (s_valid && s_ready) begin
        if (deframe_byte(s_data, rep)) report_q.push_back(rep);
        beats_in <= beats_in + 1;
      end
      if (s_valid && !s_ready) begin
        // keep offering the same beat
      end else if (tx_gap != 0) begin
        tx_gap  <= tx_gap - 1;
        s_valid <= 1'b0;
      end else if (byte_q.size() != 0 &&
                   !(byte_q[0].drain && report_q.size() != 0)) begin
        s_valid <= 1'b1;
        s_data  <= byte_q.pop_front().data;
        tx_gap  <= cycle_cnt[9] ? 0 : gap_len();
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Long master-side hold-off, once, in the middle of a long frame
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : hold
    if (!rst_ni) begin
      hold_cnt  <= 0;
      hold_done <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (!hold_done && beats_in >= 200) begin
      hold_done <= 1'b1;
      hold_cnt  <= 300;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor and master-side flow control
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : mon
    result_t got;
    result_t want;
    if (!rst_ni) begin
      m_ready  <= 1'b0;
      rx_stall <= 0;
    end else begin
      if (m_valid && m_ready) begin
        got.kind        = kind_e'(m_user);
        got.value       = m_data[7:0];
        got.position    = m_data[17:8];
        got.frame_bytes = m_data[28:18];
        got.drop_cause  = cause_e'(m_data[29]);
        if (report_q.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected report kind=%0d value=%02h", $realtime,
                     got.kind, got.value);
          mismatches <= mismatches + 1;
        end else begin
          want = report_q.pop_front();
          if (got.kind != want.kind || got.value != want.value ||
              got.position != want.position ||
              got.frame_bytes != want.frame_bytes ||
              got.drop_cause != want.drop_cause) begin
            // kind/value/position/bytes/cause
            if (mismatches < 10)
              $display("%0t: mismatch exp %0d/%02h/%0d/%0d/%0d got %0d/%02h/%0d/%0d/%0d",
                       $realtime,
                       want.kind, want.value, want.position, want.frame_bytes,
                       want.drop_cause, got.kind, got.value, got.position,
                       got.frame_bytes, got.drop_cause);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (hold_cnt != 0) begin
        m_ready  <= 1'b0;
      end else if (rx_stall != 0) begin
        rx_stall <= rx_stall - 1;
        m_ready  <= 1'b0;
      end else begin
        m_ready  <= 1'b1;
        rx_stall <= cycle_cnt[8] ? 0 : gap_len();
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_CAP) begin
      $display("bcc_frame_receiver verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin : seq
    int r;
    int len;
    int start_sz;
    int rand_bytes;

    // line noise outside a frame
    add_byte(ACK_BYTE);
    add_byte(NAK_BYTE);
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(ETX_BYTE);
    // length low byte equal to STX, then to ETX with a bad check byte
    add_frame(2, 1'b1, 1'b1, 8'h00, 1'b0);
    add_frame(3, 1'b1, 1'b0, 8'h00, 1'b0);
    // STX in the ETX slot is swallowed, not taken as a new frame start
    add_frame(1, 1'b0, 1'b1, STX_BYTE, 1'b0);
    add_byte(ACK_BYTE);
    add_frame(4, 1'b0, 1'b1, 8'hFF, 1'b0);
    // zero length, longest frame that fits, oversized length
    add_frame(0, 1'b1, 1'b1, 8'h00, 1'b0);
    add_frame(MAX_BODY, 1'b1, 1'b1, 8'h00, 1'b0);
    add_frame(16'hFFFF, 1'b1, 1'b1, 8'h00, 1'b0);

    rand_bytes = 0;
    add_byte(NAK_BYTE, 1'b1);
    while (rand_bytes < 800) begin
      start_sz = byte_q.size();
      r = $urandom_range(0, 99);
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 300)
                                         : $urandom_range(1, 16);
      if (r < 70) begin
        add_frame(len, 1'b1, $urandom_range(0, 99) < 80, 8'h00,
                  $urandom_range(0, 24) == 0);
        rand_bytes += byte_q.size() - start_sz;
      end else if (r < 82) begin
        add_frame(len, 1'b0, 1'b1, 8'($urandom), 1'b0);
        rand_bytes += byte_q.size() - start_sz;
      end else begin
        repeat ($urandom_range(1, 4)) begin
          case ($urandom_range(0, 3))
            0:       add_byte(ACK_BYTE);
            1:       add_byte(NAK_BYTE);
            default: add_byte(8'($urandom));
          endcase
        end
      end
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (byte_q.size() != 0 || s_valid) @(posedge clk_i);
    while (report_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    if (mismatches == 0 && report_q.size() == 0) begin
      $display("bcc_frame_receiver verification clean");
    end else begin
      $display("bcc_frame_receiver verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/bccfr_pkg.sv
design/bccfr_front.sv
design/bccfr_fifo.sv
design/bccfr_back.sv
design/bcc_frame_receiver.sv
tb/tb_bcc_frame_receiver.sv
